// File: rtl/dxtd_pkg.sv
// Shared types and constants of the DXT block decoder.
`timescale 1ns / 1ps

package dxtd_pkg;

    // Source block formats
    localparam logic [1:0] FMT_DXT1 = 2'd0;
    localparam logic [1:0] FMT_DXT3 = 2'd1;
    localparam logic [1:0] FMT_DXT5 = 2'd2;
    localparam logic [1:0] FMT_NONE = 2'd3;

    // Decode modes
    localparam logic [1:0] MODE_COLOR_ALPHA = 2'd0;
    localparam logic [1:0] MODE_COLOR_ONLY  = 2'd1;
    localparam logic [1:0] MODE_ALPHA_ONLY  = 2'd2;
    localparam logic [1:0] MODE_ALPHA_GREY  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_SOURCE_FORMAT   = 2'd0;
    localparam logic [1:0] REG_DECODE_MODE     = 2'd1;
    localparam logic [1:0] REG_FOUR_COMPONENTS = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;
    localparam int S_TDATA_W   = 128;
    localparam int M_TDATA_W   = 40;
    localparam int M_TUSER_W   = 2;

    // Decoded palettes and per-block controls, held while the block is emitted
    typedef struct packed {
        logic [1:0]       fmt;
        logic             grey;
        logic             color_on;
        logic             alpha_on;
        logic             rgb_written;
        logic             alpha_written;
        logic [3:0][7:0]  red;
        logic [3:0][7:0]  green;
        logic [3:0][7:0]  blue;
        logic [3:0][7:0]  alpha;
        logic [7:0][7:0]  apal;
    } pal_t;

    typedef struct packed {
        logic [1:0] pixel_x;
        logic [1:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       rgb_written;
        logic       alpha_written;
        logic       last;
    } pixel_t;

endpackage

// File: rtl/dxtd_palette.sv
// Color and alpha palette builder for one compressed block.
`timescale 1ns / 1ps

module dxtd_palette (
    input  logic [63:0]          block_low,
    input  logic [63:0]          block_high,
    input  logic [1:0]           source_format,
    input  logic [1:0]           decode_mode,
    input  logic                 four_components,
    output dxtd_pkg::pal_t       pal
);
    import dxtd_pkg::*;

    // floor(x/3) for x < 768
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [21:0] prod;
        prod = {12'd0, x} * 22'd2731;
        return prod[20:13];
    endfunction

    // floor(x/7) for x < 1792
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] prod;
        prod = {12'd0, x} * 23'd2341;
        return prod[21:14];
    endfunction

    // floor(x/5) for x < 1280
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] prod;
        prod = {12'd0, x} * 23'd3277;
        return prod[21:14];
    endfunction

    logic [15:0]      c0, c1;
    logic [2:0][7:0]  e0, e1, mid2, mid3, half;
    logic             four_color;
    logic             lo_mode;
    logic [7:0]       a0, a1;
    logic [7:0][7:0]  apal;

    always_comb begin
        c0 = (source_format == FMT_DXT1) ? block_low[15:0]  : block_high[15:0];
        c1 = (source_format == FMT_DXT1) ? block_low[31:16] : block_high[31:16];
        e0[0] = {c0[15:11], c0[15:13]};
        e0[1] = {c0[10:5],  c0[10:9]};
        e0[2] = {c0[4:0],   c0[4:2]};
        e1[0] = {c1[15:11], c1[15:13]};
        e1[1] = {c1[10:5],  c1[10:9]};
        e1[2] = {c1[4:0],   c1[4:2]};
        for (int c = 0; c < 3; c++) begin
            mid2[c] = div3({1'b0, e0[c], 1'b0} + {2'd0, e1[c]} + 10'd1);
            mid3[c] = div3({2'd0, e0[c]} + {1'b0, e1[c], 1'b0} + 10'd1);
            half[c] = 8'(({1'b0, e0[c]} + {1'b0, e1[c]}) >> 1);
        end
        four_color = (source_format != FMT_DXT1) || (c0 > c1);
        lo_mode    = (decode_mode == MODE_COLOR_ALPHA) || (decode_mode == MODE_COLOR_ONLY);
    end

    // DXT5 alpha palette
    always_comb begin
        logic [10:0] w0, w1, sum;
        a0 = block_low[7:0];
        a1 = block_low[15:8];
        apal = '0;
        apal[0] = a0;
        apal[1] = a1;
        if (a0 > a1) begin
            for (int k = 1; k <= 6; k++) begin
                w0  = 11'(7 - k);
                w1  = 11'(k);
                sum = w0 * {3'd0, a0} + w1 * {3'd0, a1} + 11'd3;
                apal[k + 1] = div7(sum);
            end
        end else begin
            for (int k = 1; k <= 4; k++) begin
                w0  = 11'(5 - k);
                w1  = 11'(k);
                sum = w0 * {3'd0, a0} + w1 * {3'd0, a1} + 11'd2;
                apal[k + 1] = div5(sum);
            end
            apal[6] = 8'h00;
            apal[7] = 8'hff;
        end
    end

    always_comb begin
        pal          = '1;
        pal.fmt      = source_format;
        pal.grey     = (decode_mode == MODE_ALPHA_GREY);
        pal.apal     = apal;
        pal.color_on = 1'b0;
        pal.alpha_on = 1'b0;
        if (source_format == FMT_DXT1) begin
            pal.rgb_written   = 1'b1;
            pal.alpha_written = four_components;
            if (lo_mode) begin
                pal.red[0] = e0[0]; pal.green[0] = e0[1]; pal.blue[0] = e0[2];
                pal.red[1] = e1[0]; pal.green[1] = e1[1]; pal.blue[1] = e1[2];
                if (four_color) begin
                    pal.red[2] = mid2[0]; pal.green[2] = mid2[1]; pal.blue[2] = mid2[2];
                    pal.red[3] = mid3[0]; pal.green[3] = mid3[1]; pal.blue[3] = mid3[2];
                end else begin
                    pal.red[2] = half[0]; pal.green[2] = half[1]; pal.blue[2] = half[2];
                    pal.red[3] = 8'h00;   pal.green[3] = 8'h00;   pal.blue[3] = 8'h00;
                    pal.alpha[3] = (decode_mode == MODE_COLOR_ALPHA) ? 8'h00 : 8'hff;
                end
            end else if (!four_color) begin
                // black entry, transparent unless in grey mode; white elsewhere
                pal.red[3]   = 8'h00;
                pal.green[3] = 8'h00;
                pal.blue[3]  = 8'h00;
                pal.alpha[3] = (decode_mode == MODE_ALPHA_GREY) ? 8'hff : 8'h00;
            end
        end else begin
            pal.color_on = lo_mode;
            pal.alpha_on = (four_components && (decode_mode != MODE_COLOR_ONLY))
                           || (decode_mode == MODE_ALPHA_GREY);
            pal.rgb_written   = lo_mode || (decode_mode == MODE_ALPHA_GREY);
            pal.alpha_written = pal.alpha_on && (decode_mode != MODE_ALPHA_GREY);
            pal.red[0] = e0[0];   pal.green[0] = e0[1];   pal.blue[0] = e0[2];
            pal.red[1] = e1[0];   pal.green[1] = e1[1];   pal.blue[1] = e1[2];
            pal.red[2] = mid2[0]; pal.green[2] = mid2[1]; pal.blue[2] = mid2[2];
            pal.red[3] = mid3[0]; pal.green[3] = mid3[1]; pal.blue[3] = mid3[2];
        end
    end

endmodule

// File: rtl/dxtd_emitter.sv
// Holds one decoded block and emits its sixteen pixels through an output register.
`timescale 1ns / 1ps

module dxtd_emitter (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 blk_valid,
    output logic                 blk_ready,
    input  dxtd_pkg::pal_t       blk_pal,
    input  logic [63:0]          blk_low,
    input  logic [63:0]          blk_high,
    output logic                 pix_valid,
    input  logic                 pix_ready,
    output dxtd_pkg::pixel_t     pix
);
    import dxtd_pkg::*;

    pal_t        pal_reg;
    logic [63:0] low_reg, high_reg;
    logic        busy_reg, busy_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    pixel_t      out_reg;

    logic        advance, load;
    pixel_t      pix_next;
    logic [1:0]  cidx;
    logic [2:0]  aidx;
    logic [7:0]  aval;
    logic [31:0] cwords;
    logic [63:0] nibs;
    logic [47:0] tribs;
    logic [5:0]  tshift;

    assign advance   = busy_reg && (!out_valid_reg || pix_ready);
    assign blk_ready = !busy_reg || (advance && (cnt_reg == 4'd15));
    assign load      = blk_valid && blk_ready;

    always_comb begin
        cwords = ((pal_reg.fmt == FMT_DXT1) ? low_reg[63:32] : high_reg[63:32])
                 >> {cnt_reg, 1'b0};
        cidx   = cwords[1:0];
        nibs   = low_reg >> {cnt_reg, 2'b00};
        tshift = {1'b0, cnt_reg, 1'b0} + {2'd0, cnt_reg};
        tribs  = low_reg[63:16] >> tshift;
        aidx   = tribs[2:0];
        aval   = (pal_reg.fmt == FMT_DXT3) ? {nibs[3:0], nibs[3:0]} : pal_reg.apal[aidx];

        pix_next         = '0;
        pix_next.pixel_x = cnt_reg[1:0];
        pix_next.pixel_y = cnt_reg[3:2];
        pix_next.last    = (cnt_reg == 4'd15);
        pix_next.rgb_written   = pal_reg.rgb_written;
        pix_next.alpha_written = pal_reg.alpha_written;
        if (pal_reg.fmt == FMT_DXT1) begin
            pix_next.red   = pal_reg.red[cidx];
            pix_next.green = pal_reg.green[cidx];
            pix_next.blue  = pal_reg.blue[cidx];
            pix_next.alpha = pal_reg.alpha[cidx];
        end else begin
            if (pal_reg.color_on) begin
                pix_next.red   = pal_reg.red[cidx];
                pix_next.green = pal_reg.green[cidx];
                pix_next.blue  = pal_reg.blue[cidx];
            end
            if (pal_reg.alpha_on) begin
                if (pal_reg.grey) begin
                    pix_next.red   = aval;
                    pix_next.green = aval;
                    pix_next.blue  = aval;
                end else begin
                    pix_next.alpha = aval;
                end
            end
        end
        // zero the bytes this mode does not produce
        if (!pal_reg.rgb_written) begin
            pix_next.red   = 8'h00;
            pix_next.green = 8'h00;
            pix_next.blue  = 8'h00;
        end
        if (!pal_reg.alpha_written) begin
            pix_next.alpha = 8'h00;
        end
    end

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (advance) begin
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15) begin
                busy_next = 1'b0;
            end
        end
        if (load) begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (pix_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pal_reg  <= blk_pal;
            low_reg  <= blk_low;
            high_reg <= blk_high;
        end
        if (advance) begin
            out_reg <= pix_next;
        end
    end

    assign pix_valid = out_valid_reg;
    assign pix       = out_reg;

endmodule

// File: rtl/dxt_block_decoder.sv
// Top level of the DXT1/DXT3/DXT5 block decoder.
`timescale 1ns / 1ps

// Usage:
//   Configure source_format, decode_mode and four_components through the
//   cfg_* write port while the block is idle. Feed compressed 4x4 blocks on
//   the s_ channel (bytes 0..7 in s_tdata[63:0], bytes 8..15 in
//   s_tdata[127:64]). Each block produces sixteen pixels on the m_ channel in
//   row order, m_tlast on the sixteenth; a block with format code 3 is
//   consumed and produces nothing.
//   On the way out a block passes the input register, which loads at the
//   accepting edge, then the palette register, then the pixel output register.
//   Throughput: one pixel per cycle while m_tready is high; the next
//   block is taken into the input register while the current one is still
//   being emitted, so blocks follow with no gap. The pixel counter that
//   walks the held palettes sets this rate.
//   A stall on m_tready holds the output pixel and the counter; the input
//   register then fills and s_tready drops.
//   Reset clears all valid flags and sets the registers to DXT1, color and
//   alpha, three components.
module dxt_block_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [dxtd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dxtd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // block_low [63:0], block_high [127:64]
    input  logic [dxtd_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pixel_x [1:0], pixel_y [3:2], red [11:4], green [19:12], blue [27:20],
    // alpha [35:28], zero [39:36]
    output logic [dxtd_pkg::M_TDATA_W-1:0]   m_tdata,
    // rgb_written [0], alpha_written [1]
    output logic [dxtd_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                            m_tlast
);
    import dxtd_pkg::*;

    logic [1:0]  fmt_reg, mode_reg;
    logic        four_reg;
    logic        in_valid_reg, in_valid_next;
    logic [63:0] low_reg, high_reg;
    logic        in_pop, blk_valid, blk_ready;
    pal_t        pal;
    pixel_t      pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg  <= FMT_DXT1;
            mode_reg <= MODE_COLOR_ALPHA;
            four_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SOURCE_FORMAT:   fmt_reg  <= cfg_wdata[1:0];
                REG_DECODE_MODE:     mode_reg <= cfg_wdata[1:0];
                REG_FOUR_COMPONENTS: four_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // drop blocks of the unknown format without emitting
    assign blk_valid = in_valid_reg && (fmt_reg != FMT_NONE);
    assign in_pop    = in_valid_reg && ((fmt_reg == FMT_NONE) || blk_ready);
    assign s_tready  = !in_valid_reg || in_pop;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (in_pop) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            low_reg  <= s_tdata[63:0];
            high_reg <= s_tdata[127:64];
        end
    end

    dxtd_palette u_palette (
        .block_low       (low_reg),
        .block_high      (high_reg),
        .source_format   (fmt_reg),
        .decode_mode     (mode_reg),
        .four_components (four_reg),
        .pal             (pal)
    );

    dxtd_emitter u_emitter (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk_pal   (pal),
        .blk_low   (low_reg),
        .blk_high  (high_reg),
        .pix_valid (m_tvalid),
        .pix_ready (m_tready),
        .pix       (pix)
    );

    assign m_tdata = {4'd0, pix.alpha, pix.blue, pix.green, pix.red,
                      pix.pixel_y, pix.pixel_x};
    assign m_tuser = {pix.alpha_written, pix.rgb_written};
    assign m_tlast = pix.last;

endmodule

// File: tb/sv/dxt_block_decoder_tb.sv
// Testbench for the DXT block decoder: directed and random blocks checked against a pixel predictor.
`timescale 1ns / 1ps

module dxt_block_decoder_tb;
    import dxtd_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int NPROBE        = 23;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_ITEMS   = 29;

    typedef struct packed {
        logic [1:0]  fmt;
        logic [1:0]  mode;
        logic        four;
        logic [63:0] lo;
        logic [63:0] hi;
        logic        typed_exp;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  a;
        logic        rgbw;
        logic        aw;
    } probe_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;

    // predictor copy of the registers
    logic [1:0] cfg_fmt;
    logic [1:0] cfg_mode;
    logic       cfg_four;

    pixel_t pending_pixels[$];
    int     fault_count;
    int     cycles;
    bit     steady;

    probe_t probes [NPROBE] = '{
        '{FMT_DXT1, MODE_COLOR_ALPHA, 1'b0, 64'h0, 64'h0,
          1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0},
        '{FMT_DXT1, MODE_COLOR_ALPHA, 1'b1, 64'hFFFF_FFFF_0000_FFFF, 64'h0,
          1'b1, 8'h55, 8'h55, 8'h55, 8'hFF, 1'b1, 1'b1},
        '{FMT_DXT1, MODE_COLOR_ALPHA, 1'b1, 64'hFFFF_FFFF_FFFF_0000, 64'h0,
          1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1},
        '{FMT_DXT1, MODE_COLOR_ALPHA, 1'b1, 64'hE4E4_E4E4_7BEF_8410, 64'h0,
          1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{FMT_DXT1, MODE_COLOR_ALPHA, 1'b1, 64'h1B1B_1B1B_F81F_07E0, 64'h0,
          1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{FMT_DXT1, MODE_COLOR_ONLY, 1'b1, 64'hFFFF_FFFF_FFFF_0000, 64'h0,
          1'b1, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1},
        '{FMT_DXT1, MODE_COLOR_ONLY, 1'b0, 64'hE4E4_E4E4_FFFF_0001, 64'h0,
          1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{FMT_DXT1, MODE_ALPHA_ONLY, 1'b1, 64'hFFFF_FFFF_FFFF_0000, 64'h0,
          1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1},
        '{FMT_DXT1, MODE_ALPHA_ONLY, 1'b0, 64'hFFFF_FFFF_0000_FFFF, 64'h0,
          1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0},
        '{FMT_DXT1, MODE_ALPHA_ONLY, 1'b1, 64'hE4E4_E4E4_FFFF_0001, 64'h0,
          1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{FMT_DXT1, MODE_ALPHA_GREY, 1'b1, 64'hFFFF_FFFF_FFFF_0000, 64'h0,
          1'b1, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1},
        '{FMT_DXT1, MODE_ALPHA_GREY, 1'b0, 64'h1234_5678_ABCD_ABCD, 64'h0,
          1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{FMT_DXT3, MODE_COLOR_ALPHA, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
          1'b1, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b1},
        '{FMT_DXT3, MODE_COLOR_ALPHA, 1'b1, 64'h0123_4567_89AB_CDEF,
          64'hE4E4_E4E4_001F_F800,
          1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{FMT_DXT3, MODE_COLOR_ONLY, 1'b0, 64'h0123_4567_89AB_CDEF,
          64'h1B1B_1B1B_07E0_F81F,
          1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{FMT_DXT3, MODE_ALPHA_ONLY, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
          64'hFFFF_FFFF_FFFF_FFFF,
          1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{FMT_DXT3, MODE_ALPHA_GREY, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
          64'hFFFF_FFFF_FFFF_FFFF,
          1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0},
        '{FMT_DXT5, MODE_ALPHA_ONLY, 1'b1, 64'h0000_0000_0000_00FF,
          64'hFFFF_FFFF_FFFF_FFFF,
          1'b1, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b1},
        '{FMT_DXT5, MODE_COLOR_ALPHA, 1'b1, 64'hFAC6_88FA_C688_0A40,
          64'hE4E4_E4E4_7BEF_8410,
          1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{FMT_DXT5, MODE_COLOR_ONLY, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
          64'h0000_0000_0000_FFFF,
          1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0},
        '{FMT_DXT5, MODE_ALPHA_GREY, 1'b0, 64'hFAC6_88FA_C688_F010, 64'h0,
          1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{FMT_DXT5, MODE_ALPHA_ONLY, 1'b1, 64'hFAC6_88FA_C688_7777,
          64'h0123_4567_89AB_CDEF,
          1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0},
        '{FMT_NONE, MODE_COLOR_ALPHA, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
          64'hFFFF_FFFF_FFFF_FFFF,
          1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0}
    };

    dxt_block_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    function automatic logic [2:0][7:0] expand_565(input logic [15:0] w);
        logic [2:0][7:0] rgb;
        rgb[0] = {w[15:11], w[15:13]};
        rgb[1] = {w[10:5], w[10:9]};
        rgb[2] = {w[4:0], w[4:2]};
        return rgb;
    endfunction

    // Work out the sixteen pixels of one block under the current registers.
    function automatic void decode_block(input logic [63:0] lo, input logic [63:0] hi);
        logic [3:0][3:0][7:0] pal;   // [entry][red, green, blue, alpha]
        logic [7:0][7:0]      apal;
        logic [31:0]          ends;
        logic [2:0][7:0]      e0;
        logic [2:0][7:0]      e1;
        logic                 dxt1;
        logic                 three_color;
        logic                 color_on;
        logic                 alpha_on;
        logic                 rgbw;
        logic                 aw;
        logic [7:0]           v;
        int unsigned          x0;
        int unsigned          x1;
        int                   c;
        int                   k;
        int                   p;
        logic [1:0]           idx;
        pixel_t               px;
        if (cfg_fmt == FMT_NONE)
            return;
        pal  = '1;
        apal = '0;
        dxt1 = (cfg_fmt == FMT_DXT1);
        color_on = (cfg_mode == MODE_COLOR_ALPHA) || (cfg_mode == MODE_COLOR_ONLY);
        alpha_on = (cfg_four && cfg_mode != MODE_COLOR_ONLY) || cfg_mode == MODE_ALPHA_GREY;
        ends = dxt1 ? lo[31:0] : hi[31:0];
        three_color = dxt1 && (ends[15:0] <= ends[31:16]);
        if (color_on) begin
            e0 = expand_565(ends[15:0]);
            e1 = expand_565(ends[31:16]);
            for (c = 0; c < 3; c++) begin
                x0 = {24'd0, e0[c]};
                x1 = {24'd0, e1[c]};
                pal[0][c] = x0[7:0];
                pal[1][c] = x1[7:0];
                if (!three_color) begin
                    pal[2][c] = 8'((2 * x0 + x1 + 1) / 3);
                    pal[3][c] = 8'((x0 + 2 * x1 + 1) / 3);
                end else begin
                    pal[2][c] = 8'((x0 + x1) / 2);
                    pal[3][c] = 8'h00;
                end
            end
            if (three_color)
                pal[3][3] = (cfg_mode == MODE_COLOR_ALPHA) ? 8'h00 : 8'hFF;
        end else if (three_color) begin
            // the black entry keeps its own alpha in the alpha modes
            pal[3][2:0] = '0;
            pal[3][3] = (cfg_mode == MODE_ALPHA_GREY) ? 8'hFF : 8'h00;
        end
        if (cfg_fmt == FMT_DXT5) begin
            x0 = {24'd0, lo[7:0]};
            x1 = {24'd0, lo[15:8]};
            apal[0] = x0[7:0];
            apal[1] = x1[7:0];
            if (x0 > x1) begin
                for (k = 1; k <= 6; k++)
                    apal[k + 1] = 8'(((7 - k) * x0 + k * x1 + 3) / 7);
            end else begin
                for (k = 1; k <= 4; k++)
                    apal[k + 1] = 8'(((5 - k) * x0 + k * x1 + 2) / 5);
                apal[6] = 8'h00;
                apal[7] = 8'hFF;
            end
        end
        rgbw = dxt1 ? 1'b1 : (color_on || cfg_mode == MODE_ALPHA_GREY);
        aw   = dxt1 ? cfg_four : (alpha_on && cfg_mode != MODE_ALPHA_GREY);

        for (p = 0; p < 16; p++) begin
            px = '0;
            if (dxt1) begin
                idx = lo[32 + 2 * p +: 2];
                px.red   = pal[idx][0];
                px.green = pal[idx][1];
                px.blue  = pal[idx][2];
                px.alpha = pal[idx][3];
            end else begin
                if (color_on) begin
                    idx = hi[32 + 2 * p +: 2];
                    px.red   = pal[idx][0];
                    px.green = pal[idx][1];
                    px.blue  = pal[idx][2];
                end
                if (alpha_on) begin
                    if (cfg_fmt == FMT_DXT3)
                        v = 8'd17 * lo[4 * p +: 4];
                    else
                        v = apal[lo[16 + 3 * p +: 3]];
                    if (cfg_mode == MODE_ALPHA_GREY) begin
                        px.red   = v;
                        px.green = v;
                        px.blue  = v;
                    end else begin
                        px.alpha = v;
                    end
                end
            end
            if (!rgbw) begin
                px.red   = 8'h00;
                px.green = 8'h00;
                px.blue  = 8'h00;
            end
            if (!aw)
                px.alpha = 8'h00;
            px.pixel_x       = p[1:0];
            px.pixel_y       = p[3:2];
            px.rgb_written   = rgbw;
            px.alpha_written = aw;
            px.last          = (p == 15);
            pending_pixels.push_back(px);
        end
    endfunction

    function automatic void expect_uniform(input probe_t row);
        pixel_t px;
        int     p;
        for (p = 0; p < 16; p++) begin
            px.pixel_x       = p[1:0];
            px.pixel_y       = p[3:2];
            px.red           = row.r;
            px.green         = row.g;
            px.blue          = row.b;
            px.alpha         = row.a;
            px.rgb_written   = row.rgbw;
            px.alpha_written = row.aw;
            px.last          = (p == 15);
            pending_pixels.push_back(px);
        end
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        case (index)
            REG_SOURCE_FORMAT:   cfg_fmt  = value;
            REG_DECODE_MODE:     cfg_mode = value;
            REG_FOUR_COMPONENTS: cfg_four = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [1:0] fmt, input logic [1:0] mode, input logic four);
        write_reg(REG_SOURCE_FORMAT, fmt);
        write_reg(REG_DECODE_MODE, mode);
        write_reg(REG_FOUR_COMPONENTS, {1'b0, four});
        cfg_wr_en <= 1'b0;
    endtask

    // Hold the sender off until every pixel is out, then let any
    // formatless block drain through the pipeline.
    task automatic settle_idle();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
        if (!steady && $urandom_range(0, 99) < 23) begin
            s_tvalid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(0, 99) < 23);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hi, lo};
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 23);
            if (m_tvalid && m_tready) begin
                got.pixel_x       = m_tdata[1:0];
                got.pixel_y       = m_tdata[3:2];
                got.red           = m_tdata[11:4];
                got.green         = m_tdata[19:12];
                got.blue          = m_tdata[27:20];
                got.alpha         = m_tdata[35:28];
                got.rgb_written   = m_tuser[0];
                got.alpha_written = m_tuser[1];
                got.last          = m_tlast;
                if (pending_pixels.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("unexpected pixel x%0d y%0d", got.pixel_x, got.pixel_y);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got !== want) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $write("pixel mismatch: expected x%0d y%0d rgba %h %h %h %h w%b%b last %b",
                                   want.pixel_x, want.pixel_y, want.red, want.green,
                                   want.blue, want.alpha, want.rgb_written,
                                   want.alpha_written, want.last);
                            $display(", got x%0d y%0d rgba %h %h %h %h w%b%b last %b",
                                     got.pixel_x, got.pixel_y, got.red, got.green,
                                     got.blue, got.alpha, got.rgb_written,
                                     got.alpha_written, got.last);
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("dxt_block_decoder_tb: done, errors");
            $finish;
        end
    end

    initial begin
        probe_t      row;
        logic [63:0] lo;
        logic [63:0] hi;
        int          i;
        int          phase;
        int          n;
        int          items;
        fault_count = 0;
        cycles      = 0;
        steady      = 1'b0;
        cfg_fmt     = FMT_DXT1;
        cfg_mode    = MODE_COLOR_ALPHA;
        cfg_four    = 1'b0;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        m_tready  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < NPROBE; i++) begin
            row = probes[i];
            if (row.fmt != cfg_fmt || row.mode != cfg_mode || row.four != cfg_four) begin
                settle_idle();
                configure(row.fmt, row.mode, row.four);
            end
            send_block(row.lo, row.hi);
            if (row.typed_exp)
                expect_uniform(row);
            else
                decode_block(row.lo, row.hi);
        end

        // one phase per format and mode, then a short run of formatless blocks
        for (phase = 0; phase <= RAND_PHASES; phase++) begin
            settle_idle();
            if (phase < RAND_PHASES)
                configure(2'(phase / 4), 2'(phase % 4), 1'((phase ^ (phase >> 2)) & 1));
            else
                configure(FMT_NONE, MODE_COLOR_ALPHA, 1'b1);
            steady = (phase == 5);
            items  = (phase < RAND_PHASES) ? PHASE_ITEMS : 5;
            for (n = 0; n < items; n++) begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
                case ($urandom_range(0, 9))
                    0: lo[31:16] = lo[15:0];
                    1: hi[31:16] = hi[15:0];
                    2: lo[15:8] = lo[7:0];
                    3: begin
                        lo = '0;
                        hi = '0;
                    end
                    4: begin
                        lo = '1;
                        hi = '1;
                    end
                    default: ;
                endcase
                send_block(lo, hi);
                decode_block(lo, hi);
            end
        end
        steady = 1'b0;
        settle_idle();

        if (fault_count == 0)
            $display("dxt_block_decoder_tb: done, clean");
        else
            $display("dxt_block_decoder_tb: done, errors");
        $finish;
    end

endmodule
